// ===== hdl/wtsp_pkg.sv =====
// Shared types, codes and helpers for the world-to-screen projection block.
// No dependencies; the projection top level uses it by scoped names.
`default_nettype none

package wtsp_pkg;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_MAC  = 7'b0000010,
      ST_DSET = 7'b0000100,
      ST_DITR = 7'b0001000,
      ST_DSTO = 7'b0010000,
      ST_SCR  = 7'b0100000,
      ST_FIN  = 7'b1000000
   } state_type;

   localparam logic       OP_LOAD     = 1'b0;
   localparam logic       OP_POINT    = 1'b1;
   localparam logic [1:0] REG_LEFT    = 2'd0;
   localparam logic [1:0] REG_TOP     = 2'd1;
   localparam logic [1:0] REG_WIDTH   = 2'd2;
   localparam logic [1:0] REG_HEIGHT  = 2'd3;
   localparam logic [1:0] TERM_OFFSET = 2'd3;

   typedef struct packed {
      logic [31:0] value;
      logic        clamp;
   } sat_type;

   function automatic sat_type sat32(input logic signed [63:0] v);
      sat_type r;
      r.clamp = 1'b1;
      if (v > 64'sd2147483647) begin
         r.value = 32'h7fff_ffff;
      end else if (v < -64'sd2147483648) begin
         r.value = 32'h8000_0000;
      end else begin
         r.value = v[31:0];
         r.clamp = 1'b0;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/world_to_screen_projection.sv =====
// Top level of the world-to-screen projection: matrix store, multiply-accumulate
// sequencer, shared restoring divider and viewport mapping. Depends on wtsp_pkg.
//
//   channel  direction  handshake            contents
//   req      in         req_valid/req_stall  operation, entry index/value, world x/y/z
//   rsp      out        rsp_valid/rsp_stall  screen x/y, depth, in_front, divided, saturated
//   csr      in         csr_write            csr_index, csr_data (16 bits)
//
// After a point's transfer, its sixteen matrix reads go through the registered store and
// the shared multiplier, then three divisions by w run on one restoring divider (one
// quotient bit per cycle), and then the viewport mapping raises the result. A zero w skips
// the divider. Reset clears the entry valid bits and the viewport registers. A stalled
// result stays in the output register; the next point can be taken, but its result waits
// in the final step for the stalled one to leave.
`default_nettype none

module world_to_screen_projection #(
   parameter int FRAC_BITS = 16
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  wire                req_operation,
   input  wire         [3:0]  req_entry_index,
   input  wire  signed [31:0] req_entry_value,
   input  wire  signed [31:0] req_world_x,
   input  wire  signed [31:0] req_world_y,
   input  wire  signed [31:0] req_world_z,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic signed [31:0] rsp_screen_x,
   output logic signed [31:0] rsp_screen_y,
   output logic signed [31:0] rsp_depth,
   output logic               rsp_in_front,
   output logic               rsp_divided,
   output logic               rsp_saturated,
   input  wire                csr_write,
   input  wire         [1:0]  csr_index,
   input  wire         [15:0] csr_data
);

   localparam int NW     = 64 + FRAC_BITS;
   localparam int OVF_SH = 33 - FRAC_BITS;
   localparam logic signed [33:0] ONE34 = 34'sd1 <<< FRAC_BITS;
   localparam logic signed [31:0] FRONT = 32'((64'sd1 <<< FRAC_BITS) / 10);

   wtsp_pkg::state_type state_ff, state_in;

   logic signed [15:0] left_ff, top_ff;
   logic        [15:0] width_ff, height_ff;

   logic        [31:0] mem [16];
   logic        [15:0] ent_vld_ff;
   logic        [31:0] rd_data_ff;
   logic               rd_ok_ff;

   logic signed [31:0] x_ff, y_ff, z_ff;
   logic        [4:0]  cnt_ff;
   logic               v1_ff, v2_ff;
   logic        [3:0]  tag1_ff, tag2_ff;
   logic signed [63:0] term_ff, acc_ff;
   logic signed [63:0] h_ff [4];

   logic        [1:0]  j_ff;
   logic        [5:0]  itr_ff;
   logic        [63:0] ud_ff, rem_ff;
   logic        [32:0] low_ff, quo_ff;
   logic               neg_ff, ovf_ff, divided_ff, sat_ff;
   logic signed [31:0] nres_ff [3];
   logic signed [49:0] px_ff, py_ff;

   logic               req_take, point_take, load_take, out_free;
   logic        [3:0]  rd_addr;
   logic signed [31:0] rd_val, coord;
   logic signed [63:0] prod, term_in, sum;
   logic signed [63:0] num, den;
   logic        [63:0] un, ud;
   logic        [NW-1:0] big_n;
   logic               ovf_in;
   logic        [64:0] t, diff;
   logic               ge;
   logic signed [63:0] qval;
   wtsp_pkg::sat_type  qsat, sx_sat, sy_sat;
   wtsp_pkg::sat_type  hsat [3];
   logic signed [33:0] ox, oy;
   logic signed [15:0] halfw, halfh;
   logic signed [63:0] sxv, syv;

   assign req_stall  = (state_ff != wtsp_pkg::ST_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign point_take = req_take && (req_operation == wtsp_pkg::OP_POINT);
   assign load_take  = req_take && (req_operation == wtsp_pkg::OP_LOAD);
   assign out_free   = !rsp_valid || !rsp_stall;

   // Entry s of the sequence is row s[3:2], column s[1:0]; the store is column-major.
   assign rd_addr = {cnt_ff[1:0], cnt_ff[3:2]};
   assign rd_val  = rd_ok_ff ? $signed(rd_data_ff) : 32'sd0;

   always_comb begin
      unique case (tag1_ff[1:0])
         2'd0:    coord = x_ff;
         2'd1:    coord = y_ff;
         default: coord = z_ff;
      endcase
   end

   assign prod    = coord * rd_val;
   assign term_in = (tag1_ff[1:0] == wtsp_pkg::TERM_OFFSET) ? 64'(rd_val) :
                    (prod >>> FRAC_BITS);
   assign sum     = acc_ff + term_ff;

   assign num    = h_ff[j_ff];
   assign den    = h_ff[3];
   assign un     = num[63] ? 64'(-num) : 64'(num);
   assign ud     = den[63] ? 64'(-den) : 64'(den);
   assign big_n  = {un, {FRAC_BITS{1'b0}}};
   assign ovf_in = {33'd0, un} >= ({33'd0, ud} << OVF_SH);

   assign t    = {rem_ff, low_ff[32]};
   assign diff = t - {1'b0, ud_ff};
   assign ge   = (t >= {1'b0, ud_ff});

   assign qval = ovf_ff ? (neg_ff ? 64'sh8000_0000_0000_0000 : 64'sh7fff_ffff_ffff_ffff) :
                 (neg_ff ? -$signed({31'd0, quo_ff}) : $signed({31'd0, quo_ff}));
   assign qsat = wtsp_pkg::sat32(qval);

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         hsat[k] = wtsp_pkg::sat32(h_ff[k]);
      end
   end

   assign halfw = $signed({1'b0, width_ff[15:1]});
   assign halfh = $signed({1'b0, height_ff[15:1]});
   assign ox    = ONE34 + 34'(nres_ff[0]);
   assign oy    = ONE34 - 34'(nres_ff[1]);
   assign sxv   = (64'(left_ff) <<< FRAC_BITS) + 64'(px_ff);
   assign syv   = (64'(top_ff) <<< FRAC_BITS) + 64'(py_ff);
   assign sx_sat = wtsp_pkg::sat32(sxv);
   assign sy_sat = wtsp_pkg::sat32(syv);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wtsp_pkg::ST_IDLE: if (point_take) state_in = wtsp_pkg::ST_MAC;
         wtsp_pkg::ST_MAC:  if (v2_ff && (tag2_ff == 4'hf)) state_in = wtsp_pkg::ST_DSET;
         wtsp_pkg::ST_DSET: begin
            if (den == 64'sd0) state_in = wtsp_pkg::ST_SCR;
            else if (ovf_in) state_in = wtsp_pkg::ST_DSTO;
            else state_in = wtsp_pkg::ST_DITR;
         end
         wtsp_pkg::ST_DITR: if (itr_ff == 6'd0) state_in = wtsp_pkg::ST_DSTO;
         wtsp_pkg::ST_DSTO: begin
            state_in = (j_ff == 2'd2) ? wtsp_pkg::ST_SCR : wtsp_pkg::ST_DSET;
         end
         wtsp_pkg::ST_SCR:  state_in = wtsp_pkg::ST_FIN;
         wtsp_pkg::ST_FIN:  if (out_free) state_in = wtsp_pkg::ST_IDLE;
         default:           state_in = wtsp_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (load_take) begin
         mem[req_entry_index] <= req_entry_value;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= wtsp_pkg::ST_IDLE;
         ent_vld_ff <= '0;
         left_ff    <= '0;
         top_ff     <= '0;
         width_ff   <= '0;
         height_ff  <= '0;
         rsp_valid  <= 1'b0;
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (load_take) begin
            ent_vld_ff[req_entry_index] <= 1'b1;
         end
         if (csr_write) begin
            unique case (csr_index)
               wtsp_pkg::REG_LEFT:   left_ff   <= $signed(csr_data);
               wtsp_pkg::REG_TOP:    top_ff    <= $signed(csr_data);
               wtsp_pkg::REG_WIDTH:  width_ff  <= csr_data;
               wtsp_pkg::REG_HEIGHT: height_ff <= csr_data;
               default: ;
            endcase
         end
         if (point_take) begin
            cnt_ff <= '0;
         end else if ((state_ff == wtsp_pkg::ST_MAC) && !cnt_ff[4]) begin
            cnt_ff <= cnt_ff + 5'd1;
         end
         v1_ff <= (state_ff == wtsp_pkg::ST_MAC) && !cnt_ff[4];
         v2_ff <= v1_ff;
         if ((state_ff == wtsp_pkg::ST_FIN) && out_free) begin
            rsp_valid <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_ok_ff <= ent_vld_ff[rd_addr];
      tag1_ff  <= cnt_ff[3:0];
      tag2_ff  <= tag1_ff;
      term_ff  <= term_in;
      if (point_take) begin
         x_ff   <= req_world_x;
         y_ff   <= req_world_y;
         z_ff   <= req_world_z;
         acc_ff <= '0;
         j_ff   <= '0;
         sat_ff <= 1'b0;
      end
      if ((state_ff == wtsp_pkg::ST_MAC) && v2_ff) begin
         if (tag2_ff[1:0] == wtsp_pkg::TERM_OFFSET) begin
            h_ff[tag2_ff[3:2]] <= sum;
            acc_ff <= '0;
         end else begin
            acc_ff <= sum;
         end
      end
      if (state_ff == wtsp_pkg::ST_DSET) begin
         divided_ff <= (den != 64'sd0);
         if (den == 64'sd0) begin
            for (int k = 0; k < 3; k++) begin
               nres_ff[k] <= $signed(hsat[k].value);
            end
            sat_ff <= hsat[0].clamp | hsat[1].clamp | hsat[2].clamp;
         end
         ud_ff  <= ud;
         neg_ff <= num[63] ^ den[63];
         ovf_ff <= ovf_in;
         rem_ff <= {{OVF_SH{1'b0}}, big_n[NW-1:33]};
         low_ff <= big_n[32:0];
         quo_ff <= '0;
         itr_ff <= 6'd32;
      end
      if (state_ff == wtsp_pkg::ST_DITR) begin
         rem_ff <= ge ? diff[63:0] : t[63:0];
         low_ff <= {low_ff[31:0], 1'b0};
         quo_ff <= {quo_ff[31:0], ge};
         itr_ff <= itr_ff - 6'd1;
      end
      if (state_ff == wtsp_pkg::ST_DSTO) begin
         nres_ff[j_ff] <= $signed(qsat.value);
         sat_ff <= sat_ff | qsat.clamp;
         j_ff   <= j_ff + 2'd1;
      end
      if (state_ff == wtsp_pkg::ST_SCR) begin
         px_ff <= halfw * ox;
         py_ff <= halfh * oy;
      end
      if ((state_ff == wtsp_pkg::ST_FIN) && out_free) begin
         rsp_screen_x  <= $signed(sx_sat.value);
         rsp_screen_y  <= $signed(sy_sat.value);
         rsp_depth     <= nres_ff[2];
         rsp_in_front  <= (nres_ff[2] > FRONT);
         rsp_divided   <= divided_ff;
         rsp_saturated <= sat_ff | sx_sat.clamp | sy_sat.clamp;
      end
   end

   a_point_starts: assert property (@(posedge clock) disable iff (reset)
      point_take |=> (state_ff == wtsp_pkg::ST_MAC) && (cnt_ff == 5'd0))
      else $error("point transfer did not start the matrix sequence");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wtsp_pkg::ST_DITR || state_ff == wtsp_pkg::ST_DSTO) |-> (h_ff[3] != 64'sd0))
      else $error("divider running with zero w");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wtsp_pkg::ST_DITR) |-> (rem_ff < ud_ff))
      else $error("divider remainder out of range");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == wtsp_pkg::ST_FIN))
      else $error("result raised outside the final step");

endmodule

`default_nettype wire
